// ===== rtl/ilp_pkg.sv =====
// Package with shared types, codes and constants of the integer literal parser.
`timescale 1ns / 1ps

package ilp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  // Literal radix
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  // Error flag held while a literal is read
  typedef enum logic [1:0] {
    EF_NONE     = 2'd0,
    EF_ILLEGAL  = 2'd1,
    EF_LONG_BIG = 2'd2
  } err_e;

  // Result error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd1;
  localparam logic [2:0] ERR_LONG_BIG  = 3'd2;
  localparam logic [2:0] ERR_INT_SMALL = 3'd3;
  localparam logic [2:0] ERR_INT_BIG   = 3'd4;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  // Overflow limits checked before the multiply
  localparam logic signed [63:0] LIM_DEC = 64'sd922337203685477580;
  localparam logic signed [63:0] LIM_OCT = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] LIM_HEX = 64'sh0FFF_FFFF_FFFF_FFFF;

  // 32-bit range limits in int mode
  localparam logic signed [63:0] INT_MIN = -64'sd2147483648;
  localparam logic signed [63:0] UINT_MAX = 64'sh0000_0000_FFFF_FFFF;

  // Parser state
  typedef struct packed {
    phase_e      phase;
    radix_e      radix;
    logic [63:0] accum;
    err_e        err;
  } parse_state_t;

  // One step's result
  typedef struct packed {
    logic        emit;
    logic [63:0] value;
    logic [2:0]  code;
  } step_res_t;

endpackage

// ===== rtl/ilp_step.sv =====
// Per-character step logic: digit decode, accumulate, overflow and range checks.
`timescale 1ns / 1ps

module ilp_step (
  input  logic [7:0]            char_i,
  input  logic                  int_mode_i,
  input  ilp_pkg::parse_state_t state_i,
  output ilp_pkg::parse_state_t state_o,
  output ilp_pkg::step_res_t    result_o
);

  logic                     is_ws;
  logic                     is_dig;
  logic [3:0]               dig;
  logic [4:0]               base;
  logic                     do_take;
  ilp_pkg::radix_e          radix_eff;
  logic [63:0]              acc_eff;
  ilp_pkg::err_e            err_eff;
  logic signed [63:0]       acc_s;
  logic signed [63:0]       limit;
  logic [63:0]              scaled;
  ilp_pkg::err_e            err_new;
  logic [2:0]               fin_code;
  logic [63:0]              fin_value;

  // Classify and decode the character
  always_comb begin
    is_ws  = (char_i == ilp_pkg::CH_SPACE) ||
             (char_i >= ilp_pkg::CH_TAB && char_i <= ilp_pkg::CH_CR);
    is_dig = 1'b1;
    dig    = 4'd0;
    if (char_i >= ilp_pkg::CH_ZERO && char_i <= ilp_pkg::CH_NINE) begin
      dig = char_i[3:0];
    end else if (char_i >= ilp_pkg::CH_LOW_A && char_i <= ilp_pkg::CH_LOW_F) begin
      dig = 4'(char_i - ilp_pkg::CH_LOW_A + 8'd10);
    end else if (char_i >= ilp_pkg::CH_UP_A && char_i <= ilp_pkg::CH_UP_F) begin
      dig = 4'(char_i - ilp_pkg::CH_UP_A + 8'd10);
    end else begin
      is_dig = 1'b0;
    end
  end

  // Effective state: a new literal starts from zero in decimal
  always_comb begin
    if (state_i.phase == ilp_pkg::PH_IDLE) begin
      radix_eff = ilp_pkg::RX_DEC;
      acc_eff   = '0;
      err_eff   = ilp_pkg::EF_NONE;
    end else begin
      radix_eff = state_i.radix;
      acc_eff   = state_i.accum;
      err_eff   = state_i.err;
    end
    acc_s = $signed(acc_eff);
  end

  // Base, overflow limit and shift-add multiply
  always_comb begin
    case (radix_eff)
      ilp_pkg::RX_OCT: begin
        base   = 5'd8;
        limit  = ilp_pkg::LIM_OCT;
        scaled = acc_eff << 3;
      end
      ilp_pkg::RX_HEX: begin
        base   = 5'd16;
        limit  = ilp_pkg::LIM_HEX;
        scaled = acc_eff << 4;
      end
      default: begin
        base   = 5'd10;
        limit  = ilp_pkg::LIM_DEC;
        scaled = (acc_eff << 3) + (acc_eff << 1);
      end
    endcase
  end

  // Digit error flags: too large overrides illegal digit
  always_comb begin
    err_new = err_eff;
    if ({1'b0, dig} >= base) begin
      err_new = ilp_pkg::EF_ILLEGAL;
    end
    if (acc_s > limit) begin
      err_new = ilp_pkg::EF_LONG_BIG;
    end
  end

  // Finish a literal: int mode range checks and truncation
  always_comb begin
    case (err_eff)
      ilp_pkg::EF_ILLEGAL:  fin_code = ilp_pkg::ERR_ILLEGAL;
      ilp_pkg::EF_LONG_BIG: fin_code = ilp_pkg::ERR_LONG_BIG;
      default:              fin_code = ilp_pkg::ERR_OK;
    endcase
    fin_value = acc_eff;
    if (int_mode_i) begin
      if (err_eff == ilp_pkg::EF_NONE) begin
        if (acc_s < ilp_pkg::INT_MIN) begin
          fin_code = ilp_pkg::ERR_INT_SMALL;
        end else if (acc_s > ilp_pkg::UINT_MAX) begin
          fin_code = ilp_pkg::ERR_INT_BIG;
        end
      end
      fin_value = {{32{acc_eff[31]}}, acc_eff[31:0]};
    end
  end

  // Next state and result
  always_comb begin
    state_o       = state_i;
    do_take       = 1'b0;
    result_o.emit  = 1'b0;
    result_o.value = fin_value;
    result_o.code  = fin_code;
    case (state_i.phase)
      ilp_pkg::PH_IDLE: begin
        if (char_i == ilp_pkg::CH_ZERO) begin
          state_o.phase = ilp_pkg::PH_ZERO;
          state_o.radix = ilp_pkg::RX_OCT;
          state_o.accum = '0;
          state_o.err   = ilp_pkg::EF_NONE;
        end else if (!is_ws) begin
          do_take = 1'b1;
        end
      end
      ilp_pkg::PH_ZERO: begin
        if (char_i == ilp_pkg::CH_LOW_X || char_i == ilp_pkg::CH_UP_X) begin
          state_o.phase = ilp_pkg::PH_DIGITS;
          state_o.radix = ilp_pkg::RX_HEX;
        end else begin
          do_take = 1'b1;
        end
      end
      default: begin
        do_take = 1'b1;
      end
    endcase

    if (do_take) begin
      if (is_dig) begin
        state_o.phase = ilp_pkg::PH_DIGITS;
        state_o.radix = radix_eff;
        state_o.accum = scaled + {60'd0, dig};
        state_o.err   = err_new;
      end else begin
        result_o.emit = 1'b1;
        state_o.phase = ilp_pkg::PH_IDLE;
        state_o.radix = ilp_pkg::RX_DEC;
        state_o.accum = '0;
        state_o.err   = ilp_pkg::EF_NONE;
      end
    end
  end

endmodule

// ===== rtl/integer_literal_parser_unit.sv =====
// Top level of the streaming C integer literal parser.
// A character is held in the input register; its result is registered in the out reg.
// Throughput: one character per cycle while the result side does not stall.
// A stall on the result side holds the input register and the parse state.
// Reset (async, active low): idle, decimal, accumulator zero, no error, int_mode 0.
// No clearing pass; the block accepts input right after reset.
`timescale 1ns / 1ps

module integer_literal_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic [2:0]         error_code_o
);

  logic                  int_mode_q;
  logic                  s1_valid_q;
  logic [7:0]            char_q;
  ilp_pkg::parse_state_t state_q;
  ilp_pkg::parse_state_t state_d;
  ilp_pkg::step_res_t    res;
  logic                  out_valid_q;
  logic [63:0]           value_q;
  logic [2:0]            code_q;
  logic                  adv;

  // Config register write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      int_mode_q <= cfg_data_i;
    end
  end

  // Advance when the output register is free or being drained
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_in_i;
    end
  end

  // Step logic
  ilp_step u_step (
    .char_i     (char_q),
    .int_mode_i (int_mode_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .result_o   (res)
  );

  // Parse state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= ilp_pkg::PH_IDLE;
      state_q.radix <= ilp_pkg::RX_DEC;
      state_q.accum <= '0;
      state_q.err   <= ilp_pkg::EF_NONE;
    end else if (s1_valid_q && adv) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && res.emit) begin
      value_q <= res.value;
      code_q  <= res.code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = $signed(value_q);
  assign error_code_o = code_q;

  // Idle state always carries a cleared accumulator and no error
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == ilp_pkg::PH_IDLE |-> state_q.accum == '0 &&
      state_q.err == ilp_pkg::EF_NONE)
    else $error("idle state holds stale accumulator or error");

  // Hex radix is only reached after the prefix, in the digit phase
  a_hex_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.radix == ilp_pkg::RX_HEX |-> state_q.phase == ilp_pkg::PH_DIGITS)
    else $error("hex radix outside digit phase");

  // Input stalls only when a held result blocks the pipeline
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Error code stays within its defined range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o <= ilp_pkg::ERR_INT_BIG)
    else $error("error code out of range");

endmodule

// ===== dv/ilp_checker.sv =====
// Checker that predicts the integer literal parser's results and compares them at its output.
`timescale 1ns / 1ps

module ilp_checker
  import ilp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         char_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [63:0] value_i,
  input  logic [2:0]         error_code_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         code;
  } literal_t;

  // Largest accumulator that may still be multiplied without flagging overflow
  localparam logic signed [63:0] DEC_GUARD  = 64'sd922337203685477580;
  localparam logic signed [63:0] OCT_GUARD  = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] HEX_GUARD  = 64'sh0FFF_FFFF_FFFF_FFFF;
  // Range accepted in int mode
  localparam logic signed [63:0] INT32_LOW  = -64'sd2147483648;
  localparam logic signed [63:0] UINT32_TOP = 64'sh0000_0000_FFFF_FFFF;

  phase_e      phase_q;
  radix_e      radix_q;
  logic [63:0] accum_q;
  err_e        err_q;
  logic        int_mode_q;
  literal_t    literals_q[$];

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  // Emit the finished literal and return to idle
  function automatic void close_literal();
    logic signed [63:0] full;
    literal_t           lit;
    full = accum_q;
    case (err_q)
      EF_ILLEGAL:  lit.code = ERR_ILLEGAL;
      EF_LONG_BIG: lit.code = ERR_LONG_BIG;
      default:     lit.code = ERR_OK;
    endcase
    lit.value = full;
    if (int_mode_q) begin
      if (err_q == EF_NONE) begin
        if (full < INT32_LOW) lit.code = ERR_INT_SMALL;
        else if (full > UINT32_TOP) lit.code = ERR_INT_BIG;
      end
      lit.value = {{32{accum_q[31]}}, accum_q[31:0]};
    end
    literals_q.push_back(lit);
    phase_q = PH_IDLE;
    radix_q = RX_DEC;
    accum_q = '0;
    err_q   = EF_NONE;
  endfunction

  // Fold one digit into the accumulator, or end the literal on a non-digit
  function automatic void add_digit(input logic [7:0] c);
    int                 d;
    logic [63:0]        base;
    logic signed [63:0] guard;
    logic signed [63:0] sacc;
    d = digit_value(c);
    if (d < 0) begin
      close_literal();
    end else begin
      case (radix_q)
        RX_OCT: begin
          base  = 64'd8;
          guard = OCT_GUARD;
        end
        RX_HEX: begin
          base  = 64'd16;
          guard = HEX_GUARD;
        end
        default: begin
          base  = 64'd10;
          guard = DEC_GUARD;
        end
      endcase
      if (64'(d) >= base) err_q = EF_ILLEGAL;
      sacc = accum_q;
      // overflow wins over an illegal digit in the same step
      if (sacc > guard) err_q = EF_LONG_BIG;
      accum_q = accum_q * base + 64'(d);
      phase_q = PH_DIGITS;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (phase_q)
      PH_IDLE: begin
        if (!is_blank(c)) begin
          accum_q = '0;
          err_q   = EF_NONE;
          if (c == CH_ZERO) begin
            radix_q = RX_OCT;
            phase_q = PH_ZERO;
          end else begin
            radix_q = RX_DEC;
            add_digit(c);
          end
        end
      end
      PH_ZERO: begin
        if (c == CH_LOW_X || c == CH_UP_X) begin
          radix_q = RX_HEX;
          phase_q = PH_DIGITS;
        end else begin
          add_digit(c);
        end
      end
      default: add_digit(c);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    literal_t exp_lit;
    if (!rst_ni) begin
      phase_q    = PH_IDLE;
      radix_q    = RX_DEC;
      accum_q    = '0;
      err_q      = EF_NONE;
      int_mode_q = 1'b0;
      literals_q.delete();
      errors_o   = 0;
    end else begin
      // Compare the result taken at this edge with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (literals_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result value %h code %0d", $time, value_i,
                     error_code_i);
        end else begin
          exp_lit = literals_q.pop_front();
          if (exp_lit.value !== value_i || exp_lit.code !== error_code_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch value exp %h got %h, code exp %0d got %0d", $time,
                       exp_lit.value, value_i, exp_lit.code, error_code_i);
          end
        end
      end
      // Track mode writes
      if (cfg_valid_i && cfg_ready_i) int_mode_q = cfg_data_i;
      // Advance the prediction on each accepted request
      if (in_valid_i && !in_stall_i) parse_char(char_in_i);
    end
    pending_o = literals_q.size();
  end

endmodule

// ===== dv/tb_integer_literal_parser_unit.sv =====
// Testbench top that feeds character streams and mode writes to the integer literal parser.
`timescale 1ns / 1ps

module tb_integer_literal_parser_unit;
  import ilp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int N_BOUNDARY  = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] value_o;
  logic [2:0]         error_code_o;

  int errors;
  int pending;
  int sent;
  int tx_gap_pct;
  int rx_gap_pct;
  bit hold_req;

  integer_literal_parser_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .error_code_o(error_code_o)
  );

  ilp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .char_in_i   (char_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_i     (value_o),
    .error_code_i(error_code_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Literals at the edges of the 32-bit and 64-bit ranges and of each radix
  function automatic string boundary_lit(input int i);
    case (i)
      0:  return "4294967295";
      1:  return "4294967296";
      2:  return "2147483648";
      3:  return "0xFFFFFFFF";
      4:  return "0x100000000";
      5:  return "0xffffffff80000000";
      6:  return "0xFFFFFFFF7FFFFFFF";
      7:  return "9223372036854775807";
      8:  return "9223372036854775808";
      9:  return "18446744073709551615";
      10: return "99999999999999999999";
      11: return "01777777777777777777777";
      12: return "02000000000000000000000";
      13: return "0xFFFFFFFFFFFFFFFF";
      14: return "0x10000000000000000";
      15: return "0x8000000000000000";
      16: return "0777";
      17: return "0x";
      18: return "0X";
      default: return "0";
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'(CH_ZERO + v);
    if ($urandom_range(0, 1) == 1) return 8'(CH_UP_A + v - 10);
    return 8'(CH_LOW_A + v - 10);
  endfunction

  // Pick a character that ends a literal
  function automatic logic [7:0] end_char();
    string punct;
    punct = ";,)+-g";
    case ($urandom_range(0, 5))
      0: return blank_char();
      1: return punct[$urandom_range(0, punct.len() - 1)];
      2: return ($urandom_range(0, 1) == 1) ? CH_LOW_X : CH_UP_X;
      3: return 8'($urandom_range(128, 255));
      4: return 8'($urandom_range(0, 8));
      default: return punct[0];
    endcase
  endfunction

  // Offer one request and hold it until taken
  task automatic send_char(input logic [7:0] c);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write the mode once nothing is in flight
  task automatic write_mode(input logic m);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random literal: mostly well formed, some with stray digits, some noise
  task automatic send_literal();
    int kind;
    int ndig;
    int base;
    bit sloppy;
    repeat ($urandom_range(0, 2)) send_char(blank_char());
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
    end else if (kind < 5) begin
      send_text(boundary_lit($urandom_range(0, N_BOUNDARY - 1)));
      send_char(end_char());
    end else begin
      ndig   = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 10);
      sloppy = ($urandom_range(0, 9) == 0);
      if (kind < 10) begin
        base = 10;
        send_char(digit_char($urandom_range(1, 9)));
        ndig--;
      end else if (kind < 14) begin
        base = 8;
        send_char(CH_ZERO);
      end else begin
        base = 16;
        send_char(CH_ZERO);
        send_char(($urandom_range(0, 1) == 1) ? CH_LOW_X : CH_UP_X);
      end
      repeat (ndig)
        send_char(digit_char((sloppy && $urandom_range(0, 2) == 0) ?
                             $urandom_range(0, 15) : $urandom_range(0, base - 1)));
      send_char(end_char());
    end
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL integer_literal_parser_unit");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    char_in_i   = 8'h00;
    sent        = 0;
    tx_gap_pct  = 0;
    rx_gap_pct  = 0;
    hold_req    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: blanks, hex, octal, bad octal digit, empty hex, byte extremes
    write_mode(1'b0);
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_text("0x1F;");
    send_text("017 ");
    send_text("089,");
    send_text("0X;");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("7A");
    send_char(8'h80);

    // Int mode with idling on both sides, then a long hold at the output
    write_mode(1'b1);
    tx_gap_pct = 20;
    rx_gap_pct = 25;
    while (sent < 100) send_literal();
    hold_req = 1'b1;
    while (sent < 180) send_literal();
    send_char(8'h3B);

    // Long mode, with one pause of the sender until all results are back
    write_mode(1'b0);
    tx_gap_pct = 10;
    rx_gap_pct = 40;
    while (sent < 260) send_literal();
    in_valid_i <= 1'b0;
    wait_drained();
    while (sent < 340) send_literal();
    send_char(8'h3B);

    // Int mode again at full rate
    write_mode(1'b1);
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    while (sent < 500) send_literal();
    send_char(8'h3B);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (5) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("PASS integer_literal_parser_unit");
    else
      $display("FAIL integer_literal_parser_unit");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ilp_pkg.sv
rtl/ilp_step.sv
rtl/integer_literal_parser_unit.sv
dv/ilp_checker.sv
dv/tb_integer_literal_parser_unit.sv
